// ===== design/ttw_pkg.sv =====
// ----------------------------------------------------------------------------
// ttw_pkg
// Types and constants for the text-mode terminal writer: command and result
// words, action codes, control characters and cell fill values.
// ----------------------------------------------------------------------------
`default_nettype none

package ttw_pkg;

  // Action codes carried in a command word
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_COLOR = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // Control characters
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_ESCAPE  = 8'h1B;

  // Cell values
  localparam logic [15:0] CELL_BLANK = 16'h0020;  // fill for a scrolled-in row
  localparam logic [15:0] CELL_RESET = 16'h0F20;  // white space on black
  localparam logic [7:0]  COLOR_RESET = 8'h0F;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  data_byte;
    logic        end_of_string;
    logic [10:0] cell_index;
  } ttw_cmd_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_column;
    logic [7:0]  current_color;
    logic        did_scroll;
  } ttw_result_t;

  // What a command word does to the screen store
  typedef struct packed {
    logic put_cell;  // store a character at the cursor
    logic scroll;    // cursor stepped past the last row
  } ttw_step_t;

endpackage

`default_nettype wire

// ===== design/ttw_screen.sv =====
// ----------------------------------------------------------------------------
// ttw_screen
// Screen cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ttw_screen #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [15:0]   wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [15:0]   rdata
);

  logic [15:0] cells [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      cells[waddr] <= wdata;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= cells[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/ttw_cursor.sv =====
// ----------------------------------------------------------------------------
// ttw_cursor
// Cursor, colour attribute and escape flag. Decodes each command word into
// a cell store step and advances the cursor when the word is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module ttw_cursor #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  parameter int AW      = 11,
  parameter int RW      = 5,
  parameter int CW      = 7
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire ttw_pkg::ttw_cmd_t cmd,
  output ttw_pkg::ttw_step_t    step,
  output logic [AW-1:0]         cell_addr,
  output logic [RW-1:0]         row,
  output logic [CW-1:0]         column,
  output logic [7:0]            color
);

  import ttw_pkg::*;

  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);
  localparam logic [AW-1:0] COLS_A   = AW'(COLUMNS);

  logic          esc_pending;
  logic          esc_pending_next;
  logic [RW-1:0] row_next;
  logic [CW-1:0] column_next;
  logic [7:0]    color_next;
  logic          row_step;

  // Linear address of the cursor cell
  assign cell_addr = AW'(AW'(row) * COLS_A + AW'(column));

  // Decode the command word
  always_comb begin
    step             = '0;
    row_step         = 1'b0;
    row_next         = row;
    column_next      = column;
    color_next       = color;
    esc_pending_next = esc_pending;
    case (cmd.action)
      ACT_WRITE: begin
        if (esc_pending) begin
          color_next       = cmd.data_byte;
          esc_pending_next = 1'b0;
        end else if (cmd.data_byte == CH_ESCAPE) begin
          esc_pending_next = 1'b1;
        end else if (cmd.data_byte == CH_NEWLINE) begin
          column_next = '0;
          row_step    = 1'b1;
        end else begin
          step.put_cell = 1'b1;
          if (column == LAST_COL) begin
            column_next = '0;
            row_step    = 1'b1;
          end else begin
            column_next = column + 1'b1;
          end
        end
        if (cmd.end_of_string) begin
          esc_pending_next = 1'b0;
        end
      end
      ACT_COLOR: begin
        color_next = cmd.data_byte;
      end
      default: begin
      end
    endcase
    // Step to the next row, or hold on the last row and scroll
    if (row_step) begin
      if (row == LAST_ROW) begin
        step.scroll = 1'b1;
      end else begin
        row_next = row + 1'b1;
      end
    end
  end

  // Hold state between accepted words
  always_ff @(posedge clk) begin
    if (rst) begin
      row         <= '0;
      column      <= '0;
      color       <= COLOR_RESET;
      esc_pending <= 1'b0;
    end else if (accept) begin
      row         <= row_next;
      column      <= column_next;
      color       <= color_next;
      esc_pending <= esc_pending_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/ttw_seq.sv =====
// ----------------------------------------------------------------------------
// ttw_seq
// Cell store sequencer: clearing pass after reset, character writes, cell
// reads, and the scroll sweep (copy rows up, then fill the bottom row).
// ----------------------------------------------------------------------------
`default_nettype none

module ttw_seq #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  parameter int AW      = 11
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire ttw_pkg::ttw_cmd_t  cmd,
  input  wire ttw_pkg::ttw_step_t step,
  input  wire logic [AW-1:0]     cell_addr,
  input  wire logic [7:0]        color,
  output logic                   busy,
  output logic                   done,
  output logic [15:0]            cell_value,
  output logic                   did_scroll,
  output logic                   mem_we,
  output logic [AW-1:0]          mem_waddr,
  output logic [15:0]            mem_wdata,
  output logic                   mem_re,
  output logic [AW-1:0]          mem_raddr,
  input  wire logic [15:0]       mem_rdata
);

  import ttw_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] COPY_END  = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);
  localparam logic [16:0]   CELLS_W   = 17'(CELLS);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_COPY  = 5'b01000,
    ST_FILL  = 5'b10000
  } state_t;

  state_t        state;
  state_t        state_next;
  logic [AW-1:0] cnt;
  logic [AW-1:0] cnt_next;
  logic          done_next;
  logic [15:0]   cell_value_next;
  logic          did_scroll_next;
  logic          in_range;

  assign busy     = (state != ST_IDLE);
  assign in_range = ({6'd0, cmd.cell_index} < CELLS_W);

  // Drive the cell store and choose the next step
  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    done_next       = 1'b0;
    cell_value_next = cell_value;
    did_scroll_next = did_scroll;
    mem_we          = 1'b0;
    mem_waddr       = cnt;
    mem_wdata       = CELL_RESET;
    mem_re          = 1'b0;
    mem_raddr       = AW'(cmd.cell_index);
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (cnt == LAST_CELL) begin
          cnt_next   = '0;
          state_next = ST_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cell_value_next = '0;
          did_scroll_next = 1'b0;
          if (cmd.action == ACT_READ && in_range) begin
            mem_re     = 1'b1;
            state_next = ST_READ;
          end else begin
            // Store the character first; a scroll then moves it up
            mem_we    = step.put_cell;
            mem_waddr = cell_addr;
            mem_wdata = {color, cmd.data_byte};
            if (step.scroll) begin
              cnt_next   = '0;
              state_next = ST_COPY;
            end else begin
              done_next = 1'b1;
            end
          end
        end
      end
      ST_READ: begin
        cell_value_next = mem_rdata;
        done_next       = 1'b1;
        state_next      = ST_IDLE;
      end
      ST_COPY: begin
        // Read one row ahead, write back the word read last cycle
        mem_re    = (cnt != COPY_END);
        mem_raddr = cnt + COLS_A;
        mem_we    = (cnt != '0);
        mem_waddr = cnt - 1'b1;
        mem_wdata = mem_rdata;
        if (cnt == COPY_END) begin
          state_next = ST_FILL;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = CELL_BLANK;
        if (cnt == LAST_CELL) begin
          cnt_next        = '0;
          did_scroll_next = 1'b1;
          done_next       = 1'b1;
          state_next      = ST_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= done_next;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    cell_value <= cell_value_next;
    did_scroll <= did_scroll_next;
  end

endmodule

`default_nettype wire

// ===== design/text_mode_terminal_writer_unit.sv =====
// ----------------------------------------------------------------------------
// text_mode_terminal_writer_unit
// Text-mode console writer: screen cell store, cursor, colour and escape
// handling, with cell readback.
//
//   channel   handshake           word
//   -------   -----------------   ------------------------------------
//   command   start / busy        action, data_byte, end_of_string,
//                                 cell_index
//   result    done (one cycle)    cell_value, cursor_row, cursor_column,
//                                 current_color, did_scroll
//
// After reset a clearing pass writes all ROWS*COLUMNS cells with busy high. A
// word that does not read a cell or scroll gives its result in the next cycle
// and busy stays low: one word per cycle. A cell read goes through the store's
// registered read port and then the read state, with busy high. A scroll holds
// busy while it sweeps the store, one cell per cycle through the single write
// port after a read-ahead, and gives its result in the cycle after. The
// receiver cannot stall: done lasts one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module text_mode_terminal_writer_unit #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire ttw_pkg::ttw_cmd_t     command,
  output logic                      done,
  output ttw_pkg::ttw_result_t      result
);

  import ttw_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);

  logic          accept;
  ttw_step_t     step;
  logic [AW-1:0] cell_addr;
  logic [RW-1:0] row;
  logic [CW-1:0] column;
  logic [7:0]    color;
  logic [15:0]   cell_value;
  logic          did_scroll;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [15:0]   mem_rdata;

  assign accept = start & ~busy;

  ttw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .AW      (AW),
    .RW      (RW),
    .CW      (CW)
  ) u_cursor (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .cmd       (command),
    .step      (step),
    .cell_addr (cell_addr),
    .row       (row),
    .column    (column),
    .color     (color)
  );

  ttw_seq #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .AW      (AW)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .cmd        (command),
    .step       (step),
    .cell_addr  (cell_addr),
    .color      (color),
    .busy       (busy),
    .done       (done),
    .cell_value (cell_value),
    .did_scroll (did_scroll),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  ttw_screen #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_screen (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Assemble the result word; cursor state holds until the next accept
  always_comb begin
    result.cell_value    = cell_value;
    result.cursor_row    = 5'(row);
    result.cursor_column = 7'(column);
    result.current_color = color;
    result.did_scroll    = did_scroll;
  end

endmodule

`default_nettype wire

// ===== tb/tb_text_mode_terminal_writer_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_mode_terminal_writer_unit
// Self-checking bench for the text-mode terminal writer. A short directed
// run covers reset contents, field extremes, escape handling, newline and
// the unused action code. A long random run of strings, reads, color words
// and noise follows, with line wraps and screen scrolls. A local console
// predictor computes every result word, and each strobed result is checked
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_text_mode_terminal_writer_unit;
  import ttw_pkg::*;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;
  localparam logic [1:0] ACT_SPARE = 2'd3;  // unused action code
  localparam int RANDOM_WORDS = 1900;
  // worst case: every word scrolls and waits out the longest gap, times three
  localparam int CYCLE_LIMIT = 3 * (RANDOM_WORDS + 200) * (2 * CELLS + 30);

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  ttw_cmd_t    command = '0;
  logic        busy;
  logic        done;
  ttw_result_t result;

  // Console predictor state
  logic [15:0] screen_model [CELLS];
  int          cur_row;
  int          cur_col;
  logic [7:0]  cur_attr;
  bit          esc_armed;

  ttw_result_t expected_results [$];
  int          mismatches = 0;
  int          words_sent = 0;
  int          reads_sent = 0;
  int          scrolls_expected = 0;
  int          wraps_expected = 0;
  int          cycle_count = 0;
  bit          no_gaps = 1'b0;

  text_mode_terminal_writer_unit #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .command(command),
    .done   (done),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Step the cursor down a row, scrolling the screen on the last row
  function automatic bit advance_row();
    if (cur_row == ROWS - 1) begin
      for (int i = 0; i < CELLS - COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
      for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_model[i] = CELL_BLANK;
      scrolls_expected++;
      return 1'b1;
    end
    cur_row++;
    return 1'b0;
  endfunction

  // Apply one command word to the console state and return the result word
  function automatic ttw_result_t console_step(input ttw_cmd_t c);
    ttw_result_t r;
    r = '0;
    case (c.action)
      ACT_WRITE: begin
        if (esc_armed) begin
          cur_attr  = c.data_byte;
          esc_armed = 1'b0;
        end else if (c.data_byte == CH_ESCAPE) begin
          esc_armed = 1'b1;
        end else if (c.data_byte == CH_NEWLINE) begin
          cur_col = 0;
          r.did_scroll = advance_row();
        end else begin
          screen_model[cur_row * COLUMNS + cur_col] = {cur_attr, c.data_byte};
          if (cur_col == COLUMNS - 1) begin
            cur_col = 0;
            wraps_expected++;
            r.did_scroll = advance_row();
          end else begin
            cur_col++;
          end
        end
        // end mark drops a pending escape
        if (c.end_of_string) esc_armed = 1'b0;
      end
      ACT_COLOR: cur_attr = c.data_byte;
      ACT_READ: begin
        if (c.cell_index < CELLS) r.cell_value = screen_model[c.cell_index];
      end
      ACT_SPARE: ;
      default: ;
    endcase
    r.cursor_row    = cur_row[4:0];
    r.cursor_column = cur_col[6:0];
    r.current_color = cur_attr;
    return r;
  endfunction

  function automatic ttw_cmd_t make_word(input logic [1:0] act, input logic [7:0] data,
                                         input logic eos, input logic [10:0] idx);
    ttw_cmd_t c;
    c.action        = act;
    c.data_byte     = data;
    c.end_of_string = eos;
    c.cell_index    = idx;
    return c;
  endfunction

  // Send one command word after a random gap and log its prediction
  task automatic send_word(input ttw_cmd_t cmd);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 13);
    @(negedge clk);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    command <= cmd;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_results.push_back(console_step(cmd));
    words_sent++;
    if (cmd.action == ACT_READ) reads_sent++;
  endtask

  task automatic send_char(input logic [7:0] ch, input logic eos);
    send_word(make_word(ACT_WRITE, ch, eos, 11'($urandom_range(0, 2047))));
  endtask

  task automatic send_color(input logic [7:0] color, input logic eos);
    send_word(make_word(ACT_COLOR, color, eos, 11'($urandom_range(0, 2047))));
  endtask

  task automatic send_read(input logic [10:0] idx, input logic eos);
    send_word(make_word(ACT_READ, 8'($urandom_range(0, 255)), eos, idx));
  endtask

  // Drop start and hold until every predicted word has come back
  task automatic wait_results();
    @(negedge clk);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  // Check each strobed result word against the oldest prediction
  always @(posedge clk) begin : check_results
    ttw_result_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result word with none expected: 0x%0h", $time, result);
      end else begin
        want = expected_results.pop_front();
        check_field("cell_value", want.cell_value, result.cell_value);
        check_field("cursor_row", 16'(want.cursor_row), 16'(result.cursor_row));
        check_field("cursor_column", 16'(want.cursor_column), 16'(result.cursor_column));
        check_field("current_color", 16'(want.current_color), 16'(result.current_color));
        check_field("did_scroll", 16'(want.did_scroll), 16'(result.did_scroll));
      end
    end
  end

  // Reset contents, last cell and reads past the end of the screen
  task automatic test_reset_screen();
    send_read(11'd0, 1'b0);
    send_read(11'(CELLS - 1), 1'b1);
    send_read(11'(CELLS), 1'b0);
    send_read(11'h7FF, 1'b1);
  endtask

  // Extreme colors and bytes, read back
  task automatic test_colors_and_bytes();
    send_color(8'h00, 1'b0);
    send_char(8'h00, 1'b0);
    send_color(8'hFF, 1'b1);
    send_char(8'hFF, 1'b1);
    send_read(11'd0, 1'b0);
    send_read(11'd1, 1'b0);
  endtask

  // Escape sequences, escape dropped by the end mark, color set while armed
  task automatic test_escape();
    send_char(CH_ESCAPE, 1'b0);
    send_char(8'h3C, 1'b1);
    send_char(CH_ESCAPE, 1'b1);
    send_char(8'h42, 1'b0);
    send_char(CH_ESCAPE, 1'b0);
    send_color(8'h12, 1'b0);
    // end mark on a read leaves the escape armed
    send_read(11'd2, 1'b1);
    send_char(8'h5A, 1'b0);
    send_char(CH_ESCAPE, 1'b0);
    send_char(CH_ESCAPE, 1'b1);
    send_read(11'd2, 1'b0);
  endtask

  // Newline and the unused action code
  task automatic test_newline_and_spare();
    send_char(CH_NEWLINE, 1'b0);
    send_word(make_word(ACT_SPARE, 8'hFF, 1'b1, 11'h7FF));
    send_word(make_word(ACT_SPARE, 8'h00, 1'b0, 11'd0));
    send_read(11'(COLUMNS), 1'b0);
  endtask

  // Short lines past the bottom row, then read back the first cell of the last two rows
  task automatic test_scroll();
    for (int r = 0; r < ROWS + 3; r++) begin
      no_gaps = ($urandom_range(0, 2) == 0);
      repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
      send_char(CH_NEWLINE, 1'b1);
    end
    send_read(11'((ROWS - 2) * COLUMNS), 1'b0);
    send_read(11'((ROWS - 1) * COLUMNS), 1'b0);
  endtask

  // Random strings with escapes and newlines, reads, color words and noise
  task automatic test_random_traffic(input int target);
    int stop_at;
    int kind;
    int len;
    int pick;
    int rd_row;
    logic [7:0] ch;
    stop_at = words_sent + target;
    while (words_sent < stop_at) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 39) == 0) wait_results();
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 12);
        for (int k = 0; k < len; k++) begin
          pick = $urandom_range(0, 99);
          if (pick < 4) begin
            ch = CH_NEWLINE;
          end else if (pick < 9) begin
            // escape, then the color byte
            send_char(CH_ESCAPE, 1'b0);
            ch = 8'($urandom_range(0, 255));
          end else if (pick < 14) begin
            ch = 8'($urandom_range(0, 255));
          end else begin
            ch = 8'($urandom_range(8'h20, 8'h7E));
          end
          send_char(ch, (k == len - 1) && ($urandom_range(0, 7) != 0));
        end
        // break the string now and then with a trailing escape
        if ($urandom_range(0, 9) == 0) send_char(CH_ESCAPE, 1'($urandom_range(0, 1)));
      end else if (kind <= 7) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 3) == 0) begin
            send_read(11'($urandom_range(0, 2047)), 1'($urandom_range(0, 1)));
          end else begin
            rd_row = (cur_row > 0) ? cur_row - $urandom_range(0, 1) : cur_row;
            send_read(11'(rd_row * COLUMNS + $urandom_range(0, COLUMNS - 1)),
                      1'($urandom_range(0, 1)));
          end
        end
      end else if (kind == 8) begin
        send_color(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        send_word(make_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)), 11'($urandom_range(0, 2047))));
      end
    end
  endtask

  // Stop a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d words outstanding",
             cycle_count, expected_results.size());
    $display("tb_text_mode_terminal_writer_unit NOT OK");
    $finish;
  end

  initial begin
    for (int i = 0; i < CELLS; i++) screen_model[i] = CELL_RESET;
    cur_row   = 0;
    cur_col   = 0;
    cur_attr  = COLOR_RESET;
    esc_armed = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_screen();
    test_colors_and_bytes();
    test_escape();
    test_newline_and_spare();
    wait_results();
    test_scroll();
    wait_results();
    test_random_traffic(RANDOM_WORDS);
    wait_results();
    repeat (2 * CELLS + 10) @(posedge clk);

    $display("covered %0d words: %0d reads, %0d line wraps, %0d scrolls",
             words_sent, reads_sent, wraps_expected, scrolls_expected);
    $display("%0d mismatches in %0d cycles", mismatches, cycle_count);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb_text_mode_terminal_writer_unit OK");
    end else begin
      $display("tb_text_mode_terminal_writer_unit NOT OK");
    end
    $finish;
  end

endmodule
